// ===== rtl/prrs_pkg.sv =====
// Package for the process-table round-robin scheduler.
// Holds command codes, controller states and the transfer structs.
// No dependencies.
`timescale 1ns / 1ps

package prrs_pkg;

  // Pid width inside the cell chain, sized for tables of up to 127 slots plus idle
  localparam int PID_W  = 7;
  localparam int TPID_W = 4;
  localparam int TERM_W = 2;
  localparam int CMD_W  = 3;
  localparam int OUT_PID_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_SPAWN = 3'd0,
    CMD_EXIT  = 3'd1,
    CMD_WAIT  = 3'd2,
    CMD_BLOCK = 3'd3,
    CMD_WAKE  = 3'd4,
    CMD_SCHED = 3'd5
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TPID_W-1:0] target_pid;
    logic [TERM_W-1:0] terminal;
  } request_t;

  typedef struct packed {
    logic [OUT_PID_W-1:0] current_pid_out;
    logic [TPID_W-1:0]    spawned_pid;
    logic                 spawn_ok;
  } result_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [TPID_W-1:0] target_pid;
    logic [TERM_W-1:0] terminal;
    logic              term_ok;
    logic              cur_ok;
    logic [PID_W-1:0]  cur_pid;
    logic [PID_W-1:0]  scan_base;
    logic [TERM_W-1:0] cur_term;
    logic              free_found;
    logic [PID_W-1:0]  free_idx;
    logic              hi_found;
    logic [PID_W-1:0]  hi_idx;
    logic [TERM_W-1:0] hi_term;
    logic              lo_found;
    logic [PID_W-1:0]  lo_idx;
    logic [TERM_W-1:0] lo_term;
  } scan_pkt_t;

endpackage

// ===== rtl/process_table_round_robin_scheduler_top.sv =====
// Top level of the process-table round-robin scheduler.
// Controller plus a chain of NUM_PROCS slot cells; depends on prrs_pkg,
// prrs_ctrl and prrs_cell.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   command  | start, busy          | request (cmd, target_pid, terminal)
//   result   | done (one cycle)     | result (current_pid_out, spawned_pid,
//            |                      |         spawn_ok)
//
// Each command walks the slot chain one cell per cycle; the done strobe is
// registered after the packet leaves the last cell, and the next command
// transfers in the cycle done is high, so only one command is in flight at a time.
// Reset leaves slot 0 present and current, all other slots free.
// Done is not held; the receiver takes each result in its strobe cycle.
`timescale 1ns / 1ps

module process_table_round_robin_scheduler_top #(
  parameter int NUM_PROCS     = 16,
  parameter int NUM_TERMINALS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  prrs_pkg::request_t  request,
  output logic                busy,
  output logic                done,
  output prrs_pkg::result_t   result
);

  logic                chain_valid [NUM_PROCS+1];
  prrs_pkg::scan_pkt_t chain_pkt   [NUM_PROCS+1];

  prrs_ctrl #(
    .NUM_PROCS     (NUM_PROCS),
    .NUM_TERMINALS (NUM_TERMINALS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .request    (request),
    .busy       (busy),
    .head_valid (chain_valid[0]),
    .head_pkt   (chain_pkt[0]),
    .tail_valid (chain_valid[NUM_PROCS]),
    .tail_pkt   (chain_pkt[NUM_PROCS]),
    .done       (done),
    .result     (result)
  );

  for (genvar g = 0; g < NUM_PROCS; g++) begin : g_cell
    prrs_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[g]),
      .in_pkt    (chain_pkt[g]),
      .out_valid (chain_valid[g+1]),
      .out_pkt   (chain_pkt[g+1])
    );
  end

endmodule

// ===== rtl/prrs_cell.sv =====
// One process slot of the scheduler chain.
// Updates its slot as the command packet passes and forwards the packet.
// Depends on prrs_pkg.
`timescale 1ns / 1ps

module prrs_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  prrs_pkg::scan_pkt_t  in_pkt,
  output logic                 out_valid,
  output prrs_pkg::scan_pkt_t  out_pkt
);

  localparam int PW = prrs_pkg::PID_W;
  localparam logic [PW-1:0] MY_IDX = PW'(CELL_IDX);

  logic                          present, present_next;
  logic                          wait_valid, wait_valid_next;
  logic [prrs_pkg::TPID_W-1:0]   wait_pid, wait_pid_next;
  logic                          wait_input, wait_input_next;
  logic [prrs_pkg::TERM_W-1:0]   slot_term, slot_term_next;
  prrs_pkg::scan_pkt_t           pkt_next;
  logic                          is_cur;
  logic                          resumable;

  always_comb begin
    present_next    = present;
    wait_valid_next = wait_valid;
    wait_pid_next   = wait_pid;
    wait_input_next = wait_input;
    slot_term_next  = slot_term;
    pkt_next        = in_pkt;
    is_cur    = in_pkt.cur_ok && (in_pkt.cur_pid == MY_IDX);
    resumable = present && !wait_valid && !wait_input;
    if (in_valid) begin
      case (in_pkt.cmd)
        prrs_pkg::CMD_SPAWN: begin
          if (!present && !in_pkt.free_found) begin
            present_next        = 1'b1;
            wait_valid_next     = 1'b0;
            wait_pid_next       = '0;
            wait_input_next     = 1'b0;
            slot_term_next      = in_pkt.cur_term;
            pkt_next.free_found = 1'b1;
            pkt_next.free_idx   = MY_IDX;
          end
        end
        prrs_pkg::CMD_EXIT: begin
          if (in_pkt.cur_ok) begin
            if (is_cur) begin
              present_next = 1'b0;
            end
            if (wait_valid && (PW'(wait_pid) == in_pkt.cur_pid)) begin
              wait_valid_next = 1'b0;
            end
          end
        end
        prrs_pkg::CMD_WAIT: begin
          if (is_cur) begin
            wait_valid_next = 1'b1;
            wait_pid_next   = in_pkt.target_pid;
          end
        end
        prrs_pkg::CMD_BLOCK: begin
          if (is_cur) begin
            wait_input_next = 1'b1;
          end
        end
        prrs_pkg::CMD_WAKE: begin
          if (in_pkt.term_ok && wait_input && (slot_term == in_pkt.terminal)) begin
            wait_input_next = 1'b0;
          end
        end
        prrs_pkg::CMD_SCHED: begin
          if (resumable) begin
            if (MY_IDX > in_pkt.scan_base) begin
              if (!in_pkt.hi_found) begin
                pkt_next.hi_found = 1'b1;
                pkt_next.hi_idx   = MY_IDX;
                pkt_next.hi_term  = slot_term;
              end
            end else if (!in_pkt.lo_found) begin
              pkt_next.lo_found = 1'b1;
              pkt_next.lo_idx   = MY_IDX;
              pkt_next.lo_term  = slot_term;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present    <= (CELL_IDX == 0);
      wait_valid <= 1'b0;
      wait_pid   <= '0;
      wait_input <= 1'b0;
      slot_term  <= '0;
      out_valid  <= 1'b0;
    end else begin
      present    <= present_next;
      wait_valid <= wait_valid_next;
      wait_pid   <= wait_pid_next;
      wait_input <= wait_input_next;
      slot_term  <= slot_term_next;
      out_valid  <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_pkt <= pkt_next;
  end

endmodule

// ===== rtl/prrs_ctrl.sv =====
// Command controller of the scheduler: current pid, packet launch and result.
// Launches one packet into the cell chain and finishes it at the tail.
// Depends on prrs_pkg.
`timescale 1ns / 1ps

module prrs_ctrl #(
  parameter int NUM_PROCS     = 16,
  parameter int NUM_TERMINALS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  prrs_pkg::request_t   request,
  output logic                 busy,
  output logic                 head_valid,
  output prrs_pkg::scan_pkt_t  head_pkt,
  input  logic                 tail_valid,
  input  prrs_pkg::scan_pkt_t  tail_pkt,
  output logic                 done,
  output prrs_pkg::result_t    result
);

  localparam int CUR_W = $clog2(NUM_PROCS + 1);
  localparam int PW    = prrs_pkg::PID_W;
  localparam logic [CUR_W-1:0] IDLE_PID = CUR_W'(NUM_PROCS);

  prrs_pkg::ctrl_state_t          state, state_next;
  logic [CUR_W-1:0]               current_pid, current_pid_next;
  logic [prrs_pkg::TERM_W-1:0]    cur_term, cur_term_next;
  logic                           accept;
  logic                           finish;
  logic                           cur_ok;
  prrs_pkg::scan_pkt_t            launch_pkt;
  prrs_pkg::result_t              result_next;

  assign busy   = (state != prrs_pkg::ST_IDLE);
  assign cur_ok = (current_pid < IDLE_PID);

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    finish     = 1'b0;
    unique case (state)
      prrs_pkg::ST_IDLE: begin
        if (start) begin
          accept     = 1'b1;
          state_next = prrs_pkg::ST_SCAN;
        end
      end
      prrs_pkg::ST_SCAN: begin
        if (tail_valid) begin
          finish     = 1'b1;
          state_next = prrs_pkg::ST_IDLE;
        end
      end
      default: state_next = prrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    launch_pkt            = '0;
    launch_pkt.cmd        = prrs_pkg::cmd_t'(request.cmd);
    launch_pkt.target_pid = request.target_pid;
    launch_pkt.terminal   = request.terminal;
    launch_pkt.term_ok    = (int'(request.terminal) < NUM_TERMINALS);
    launch_pkt.cur_ok     = cur_ok;
    launch_pkt.cur_pid    = PW'(current_pid);
    launch_pkt.scan_base  = cur_ok ? PW'(current_pid) : '0;
    launch_pkt.cur_term   = cur_term;
  end

  always_comb begin
    current_pid_next = current_pid;
    cur_term_next    = cur_term;
    if (tail_pkt.cmd == prrs_pkg::CMD_SCHED) begin
      if (tail_pkt.hi_found) begin
        current_pid_next = CUR_W'(tail_pkt.hi_idx);
        cur_term_next    = tail_pkt.hi_term;
      end else if (tail_pkt.lo_found) begin
        current_pid_next = CUR_W'(tail_pkt.lo_idx);
        cur_term_next    = tail_pkt.lo_term;
      end else begin
        current_pid_next = IDLE_PID;
        cur_term_next    = '0;
      end
    end
    result_next.current_pid_out = prrs_pkg::OUT_PID_W'(current_pid_next);
    if ((tail_pkt.cmd == prrs_pkg::CMD_SPAWN) && tail_pkt.free_found) begin
      result_next.spawned_pid = prrs_pkg::TPID_W'(tail_pkt.free_idx);
      result_next.spawn_ok    = 1'b1;
    end else begin
      result_next.spawned_pid = '0;
      result_next.spawn_ok    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= prrs_pkg::ST_IDLE;
      current_pid <= '0;
      cur_term    <= '0;
      head_valid  <= 1'b0;
      done        <= 1'b0;
    end else begin
      state      <= state_next;
      head_valid <= accept;
      done       <= finish;
      if (finish) begin
        current_pid <= current_pid_next;
        cur_term    <= cur_term_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_pkt <= launch_pkt;
    end
    if (finish) begin
      result <= result_next;
    end
  end

endmodule
